/* sv/gctb_pkg.sv */
// Package for the greedy capacitated tour builder.
// Holds sizes, codes and shared types; no dependencies.
package gctb_pkg;
	localparam int MaxNodes = 32;
	localparam int IdxBits = 5;
	localparam int CntBits = 6;
	localparam int CoordBits = 12;
	localparam int DemBits = 16;
	localparam int CostBits = 20;
	localparam int SqBits = 2 * CoordBits + 1;
	localparam int RootBits = CoordBits + 1;
	localparam logic [CostBits-1:0] CostMax = '1;

	localparam logic [1:0] CfgCapacity = 2'd0;
	localparam logic [1:0] CfgDepotX = 2'd1;
	localparam logic [1:0] CfgDepotY = 2'd2;

	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StDemand = 2'd1;
	localparam logic [1:0] StEmpty = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_TOUR, S_READ, S_SQRT, S_CMP, S_DECIDE, S_RET, S_RETSQ, S_EMIT, S_FLUSH
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic start_solve;
		logic start_tour;
		logic start_scan;
		logic read_node;
		logic sqrt_start;
		logic compare;
		logic next_node;
		logic visit;
		logic start_return;
		logic close_tour;
		logic pend_to_out;
		logic out_err;
		logic [1:0] err_code;
		logic pend_last;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic scan_done;
		logic node_skip;
		logic sqrt_done;
		logic found;
		logic fits;
		logic empty;
		logic pend_valid;
		logic tour_len_zero;
		logic out_free;
	} stat_t;
endpackage

/* sv/gctb_isqrt.sv */
// Bit-serial integer square root, one result bit per cycle.
// Depends on gctb_pkg.
module gctb_isqrt import gctb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SqBits-1:0]   radicand,
	output logic                done,
	output logic [RootBits-1:0] root
);
	logic [SqBits-1:0]   rem_q;
	logic [RootBits-1:0] root_q;
	logic [4:0]          step_q;
	logic                busy_q;
	logic                done_q;
	logic [SqBits+1:0]   trial;
	logic [SqBits+1:0]   rem_sh;

	// Restoring method: bring down two bits, try 4r+1.
	always_comb begin
		rem_sh = {rem_q, 2'b00} | (SqBits+2)'(radicand >> (2 * step_q) & 2'b11);
		trial = (SqBits+2)'({root_q, 2'b01});
	end

	// The done flag rises in the cycle after the last step, once the root is final.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= 5'(RootBits - 1);
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && step_q == 0;
			if (busy_q) begin
				if (step_q == 0) busy_q <= 1'b0;
				else step_q <= step_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			if (rem_sh >= trial) begin
				rem_q <= SqBits'(rem_sh - trial);
				root_q <= {root_q[RootBits-2:0], 1'b1};
			end else begin
				rem_q <= SqBits'(rem_sh);
				root_q <= {root_q[RootBits-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

/* sv/gctb_datapath.sv */
// Datapath: node store, distance unit, nearest search and result register.
// Depends on gctb_pkg and gctb_isqrt.
module gctb_datapath import gctb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output stat_t               stat,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic [CoordBits-1:0] in_x,
	input  logic [CoordBits-1:0] in_y,
	input  logic [DemBits-1:0]  in_demand,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [4:0]          out_tour,
	output logic [CntBits-1:0]  out_node,
	output logic [CostBits-1:0] out_cost,
	output logic                out_eot,
	output logic [1:0]          out_status,
	output logic                out_last
);
	logic [CoordBits-1:0] mem_x [MaxNodes];
	logic [CoordBits-1:0] mem_y [MaxNodes];
	logic [DemBits-1:0]   mem_d [MaxNodes];

	logic [DemBits-1:0]   capacity_q;
	logic [CoordBits-1:0] depot_x_q, depot_y_q;
	logic [CntBits-1:0]   loaded_q;
	logic [MaxNodes-1:0]  visited_q;
	logic [CoordBits-1:0] cur_x_q, cur_y_q;
	logic [DemBits-1:0]   remain_q;
	logic [CostBits-1:0]  run_cost_q;
	logic [4:0]           tour_q;
	logic [CntBits-1:0]   tour_len_q;
	logic [CntBits-1:0]   scan_q;
	logic [CoordBits-1:0] rd_x_q, rd_y_q;
	logic [DemBits-1:0]   rd_d_q;
	logic                 found_q;
	logic [IdxBits-1:0]   best_q;
	logic [RootBits-1:0]  best_d_q;
	logic [DemBits-1:0]   best_dem_q;
	logic [CoordBits-1:0] best_x_q, best_y_q;
	logic [SqBits-1:0]    sq_q;

	logic                 pend_v_q;
	logic [4:0]           pend_tour_q;
	logic [CntBits-1:0]   pend_node_q;
	logic [CostBits-1:0]  pend_cost_q;
	logic                 pend_eot_q, pend_last_q;

	logic                 ov_q;
	logic [4:0]           o_tour_q;
	logic [CntBits-1:0]   o_node_q;
	logic [CostBits-1:0]  o_cost_q;
	logic                 o_eot_q, o_last_q;
	logic [1:0]           o_stat_q;

	logic [CoordBits-1:0] ax, ay, bx, by, ddx, ddy;
	logic                 sq_done;
	logic [RootBits-1:0]  root;
	logic [CostBits:0]    cost_sum;
	logic [IdxBits-1:0]   rd_addr;

	// Distance operands: scan compares current against the read node; the
	// return leg compares current against the depot.
	always_comb begin
		ax = cur_x_q;
		ay = cur_y_q;
		bx = cmd.start_return ? depot_x_q : rd_x_q;
		by = cmd.start_return ? depot_y_q : rd_y_q;
		ddx = ax > bx ? ax - bx : bx - ax;
		ddy = ay > by ? ay - by : by - ay;
	end

	always_ff @(posedge clk) begin
		if (cmd.read_node || cmd.start_return)
			sq_q <= SqBits'(ddx) * SqBits'(ddx) + SqBits'(ddy) * SqBits'(ddy);
	end

	// The square is registered the cycle before the root unit starts.
	gctb_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(cmd.sqrt_start), .radicand(sq_q),
		.done(sq_done), .root(root)
	);

	// A visit adds the chosen node's distance; closing a tour adds the return leg.
	always_comb cost_sum = {1'b0, run_cost_q} + (CostBits+1)'(cmd.visit ? best_d_q : root);

	// A new scan starts at the first store entry.
	always_comb rd_addr = cmd.start_scan ? '0 : scan_q[IdxBits-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load && loaded_q != CntBits'(MaxNodes)) begin
			mem_x[loaded_q[IdxBits-1:0]] <= in_x;
			mem_y[loaded_q[IdxBits-1:0]] <= in_y;
			mem_d[loaded_q[IdxBits-1:0]] <= in_demand;
		end
		if (cmd.start_scan || cmd.next_node) begin
			rd_x_q <= mem_x[rd_addr];
			rd_y_q <= mem_y[rd_addr];
			rd_d_q <= mem_d[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 16'd100;
			depot_x_q <= '0;
			depot_y_q <= '0;
			loaded_q <= '0;
			visited_q <= '0;
			cur_x_q <= '0;
			cur_y_q <= '0;
			remain_q <= '0;
			run_cost_q <= '0;
			tour_q <= '0;
			tour_len_q <= '0;
			scan_q <= '0;
			found_q <= 1'b0;
			best_q <= '0;
			best_d_q <= '0;
			best_dem_q <= '0;
			best_x_q <= '0;
			best_y_q <= '0;
			pend_v_q <= 1'b0;
			pend_tour_q <= '0;
			pend_node_q <= '0;
			pend_cost_q <= '0;
			pend_eot_q <= 1'b0;
			pend_last_q <= 1'b0;
			ov_q <= 1'b0;
			o_tour_q <= '0;
			o_node_q <= '0;
			o_cost_q <= '0;
			o_eot_q <= 1'b0;
			o_last_q <= 1'b0;
			o_stat_q <= StOk;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CfgCapacity: capacity_q <= cfg_data;
					CfgDepotX: depot_x_q <= cfg_data[CoordBits-1:0];
					CfgDepotY: depot_y_q <= cfg_data[CoordBits-1:0];
					default: ;
				endcase
			end
			if (cmd.load && loaded_q != CntBits'(MaxNodes))
				loaded_q <= loaded_q + 1'b1;
			if (cmd.start_solve) begin
				visited_q <= '0;
				tour_q <= '0;
				pend_v_q <= 1'b0;
			end
			if (cmd.start_tour) begin
				cur_x_q <= depot_x_q;
				cur_y_q <= depot_y_q;
				remain_q <= capacity_q;
				run_cost_q <= '0;
				tour_len_q <= '0;
				if (!cmd.start_solve) tour_q <= tour_q + 1'b1;
			end
			if (cmd.start_scan) begin
				scan_q <= 6'd1;
				found_q <= 1'b0;
			end
			if (cmd.next_node) scan_q <= scan_q + 1'b1;
			if (cmd.compare) begin
				if (!found_q || root < best_d_q) begin
					found_q <= 1'b1;
					best_q <= IdxBits'(scan_q - 1'b1);
					best_d_q <= root;
					best_dem_q <= rd_d_q;
					best_x_q <= rd_x_q;
					best_y_q <= rd_y_q;
				end
			end
			if (cmd.visit) begin
				run_cost_q <= cost_sum[CostBits] ? CostMax : cost_sum[CostBits-1:0];
				remain_q <= remain_q - best_dem_q;
				cur_x_q <= best_x_q;
				cur_y_q <= best_y_q;
				visited_q[best_q] <= 1'b1;
				tour_len_q <= tour_len_q + 1'b1;
				pend_v_q <= 1'b1;
				pend_tour_q <= tour_q;
				pend_node_q <= CntBits'(best_q) + 1'b1;
				pend_cost_q <= '0;
				pend_eot_q <= 1'b0;
				pend_last_q <= 1'b0;
			end
			if (cmd.close_tour) begin
				pend_cost_q <= cost_sum[CostBits] ? CostMax : cost_sum[CostBits-1:0];
				pend_eot_q <= 1'b1;
			end
			if (cmd.pend_last) pend_last_q <= 1'b1;
			if (ov_q && out_ready) ov_q <= 1'b0;
			if (cmd.pend_to_out) begin
				ov_q <= 1'b1;
				pend_v_q <= 1'b0;
				o_tour_q <= pend_tour_q;
				o_node_q <= pend_node_q;
				o_cost_q <= pend_cost_q;
				o_eot_q <= pend_eot_q;
				o_last_q <= pend_last_q || cmd.pend_last;
				o_stat_q <= StOk;
			end else if (cmd.out_err) begin
				ov_q <= 1'b1;
				o_tour_q <= '0;
				o_node_q <= '0;
				o_cost_q <= '0;
				o_eot_q <= 1'b0;
				o_last_q <= 1'b1;
				o_stat_q <= cmd.err_code;
			end
		end
	end

	always_comb begin
		stat.scan_done = scan_q > loaded_q;
		stat.node_skip = visited_q[IdxBits'(scan_q - 1'b1)];
		stat.sqrt_done = sq_done;
		stat.found = found_q;
		stat.fits = best_dem_q <= remain_q;
		stat.empty = loaded_q == '0;
		stat.pend_valid = pend_v_q;
		stat.tour_len_zero = tour_len_q == '0;
		stat.out_free = !ov_q || out_ready;
	end

	assign out_valid = ov_q;
	assign out_tour = o_tour_q;
	assign out_node = o_node_q;
	assign out_cost = o_cost_q;
	assign out_eot = o_eot_q;
	assign out_status = o_stat_q;
	assign out_last = o_last_q;
endmodule

/* sv/gctb_ctrl.sv */
// Controller state machine sequencing loads, scans, visits and results.
// Depends on gctb_pkg.
module gctb_ctrl import gctb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  logic  in_cmd,
	input  stat_t stat,
	output cmd_t  cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = stat.out_free;
				if (in_valid && stat.out_free) begin
					if (!in_cmd) begin
						cmd.load = 1'b1;
					end else if (stat.empty) begin
						cmd.out_err = 1'b1;
						cmd.err_code = StEmpty;
					end else begin
						cmd.start_solve = 1'b1;
						cmd.start_tour = 1'b1;
						state_d = S_TOUR;
					end
				end
			end
			S_TOUR: begin
				cmd.start_scan = 1'b1;
				state_d = S_READ;
			end
			// Read registered; go past visited nodes.
			S_READ: begin
				if (stat.scan_done) begin
					state_d = S_DECIDE;
				end else if (stat.node_skip) begin
					cmd.next_node = 1'b1;
				end else begin
					cmd.read_node = 1'b1;
					state_d = S_SQRT;
				end
			end
			S_SQRT: begin
				cmd.sqrt_start = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				if (stat.sqrt_done) begin
					cmd.compare = 1'b1;
					cmd.next_node = 1'b1;
					state_d = S_READ;
				end
			end
			S_DECIDE: begin
				if (stat.found && stat.fits) begin
					// The previous result must leave the holding slot first.
					if (!stat.pend_valid) begin
						cmd.visit = 1'b1;
						state_d = S_TOUR;
					end else if (stat.out_free) begin
						cmd.pend_to_out = 1'b1;
					end
				end else if (stat.tour_len_zero) begin
					if (stat.out_free) begin
						cmd.out_err = 1'b1;
						cmd.err_code = StDemand;
						state_d = S_IDLE;
					end
				end else begin
					cmd.start_return = 1'b1;
					state_d = S_RETSQ;
				end
			end
			S_RETSQ: begin
				cmd.sqrt_start = 1'b1;
				state_d = S_RET;
			end
			S_RET: begin
				if (stat.sqrt_done) begin
					cmd.close_tour = 1'b1;
					cmd.pend_last = !stat.found;
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (stat.out_free) begin
					cmd.pend_to_out = 1'b1;
					if (stat.found) begin
						cmd.start_tour = 1'b1;
						state_d = S_TOUR;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_EMIT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end
endmodule

/* sv/greedy_capacitated_tour_builder.sv */
// Top level of the greedy capacitated tour builder.
// Depends on gctb_pkg, gctb_ctrl and gctb_datapath.
// A load request writes the next node into the store while idle. A solve
// request scans every unvisited node for each step of a tour; each candidate
// is read from the store, squared and passed through the bit-serial square
// root unit (13 root steps) before it is compared, and a visited node is
// passed over without a distance. New requests are taken only after the
// solve has finished; a holding slot and one result register decouple
// the output.
module greedy_capacitated_tour_builder import gctb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic        s_axis_tuser,  // cmd
	input  logic [39:0] s_axis_tdata,  // node_x, node_y, node_demand
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // tour_number, node_number, tour_cost, end_of_tour
	output logic [1:0]  m_axis_tuser,  // status
	output logic        m_axis_tlast
);
	cmd_t  cmd;
	stat_t stat;
	logic [4:0]          o_tour;
	logic [CntBits-1:0]  o_node;
	logic [CostBits-1:0] o_cost;
	logic                o_eot;

	gctb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_cmd(s_axis_tuser), .stat(stat), .cmd(cmd)
	);

	gctb_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_x(s_axis_tdata[11:0]), .in_y(s_axis_tdata[23:12]),
		.in_demand(s_axis_tdata[39:24]),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_tour(o_tour), .out_node(o_node), .out_cost(o_cost), .out_eot(o_eot),
		.out_status(m_axis_tuser), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {o_eot, o_cost, o_node, o_tour};
endmodule

/* sv/gctb_checker.sv */
// Port checker for the tour builder, bound to the top level.
// Depends on gctb_pkg.
module gctb_checker import gctb_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != StOk |-> m_axis_tlast)
		else $error("error result not final");
	a_last_eot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast && m_axis_tuser == StOk |-> m_axis_tdata[31])
		else $error("final result without end of tour");
	a_node: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == StOk |-> m_axis_tdata[10:5] != 6'd0)
		else $error("ok result with zero node");
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
		else $error("request taken while the result register is blocked");
endmodule

bind greedy_capacitated_tour_builder gctb_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);
